/* design/dpcv_pkg.sv */
// Package for the DER primitive content validator.
// Holds tag codes, status codes and character-class helper functions.
package dpcv_pkg;

  localparam logic [4:0] TAG_BOOLEAN    = 5'd1;
  localparam logic [4:0] TAG_INTEGER    = 5'd2;
  localparam logic [4:0] TAG_BIT_STRING = 5'd3;
  localparam logic [4:0] TAG_OCTET      = 5'd4;
  localparam logic [4:0] TAG_NULL       = 5'd5;
  localparam logic [4:0] TAG_OID        = 5'd6;
  localparam logic [4:0] TAG_REAL       = 5'd9;
  localparam logic [4:0] TAG_ENUM       = 5'd10;
  localparam logic [4:0] TAG_UTF8       = 5'd12;
  localparam logic [4:0] TAG_REL_OID    = 5'd13;
  localparam logic [4:0] TAG_NUMERIC    = 5'd18;
  localparam logic [4:0] TAG_PRINTABLE  = 5'd19;
  localparam logic [4:0] TAG_IA5        = 5'd22;
  localparam logic [4:0] TAG_UTC_TIME   = 5'd23;
  localparam logic [4:0] TAG_GEN_TIME   = 5'd24;
  localparam logic [4:0] TAG_VISIBLE    = 5'd26;
  localparam logic [4:0] TAG_UNIVERSAL  = 5'd28;
  localparam logic [4:0] TAG_BMP        = 5'd30;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_INVALID     = 2'd1;
  localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

  localparam logic [1:0] TPH_MAIN = 2'd0;
  localparam logic [1:0] TPH_FRAC = 2'd1;
  localparam logic [1:0] TPH_DONE = 2'd2;

  // Running per-element state shared between the checker and the top level.
  typedef struct packed {
    logic        error_seen;
    logic [7:0]  lead_byte;
    logic [7:0]  prior_byte;
    logic        in_cont;
    logic [2:0]  u8_need;
    logic [2:0]  u8_seen;
    logic [20:0] u8_point;
    logic [23:0] unit_acc;
    logic [1:0]  time_phase;
    logic [1:0]  unit_phase;
  } elem_state_t;

  function automatic logic is_dig(input logic [7:0] c);
    is_dig = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_printable(input logic [7:0] c);
    logic r;
    r = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || is_dig(c);
    r = r || c == 8'h20 || c == 8'h27 || c == 8'h28 || c == 8'h29 || c == 8'h2B
          || c == 8'h2C || c == 8'h2D || c == 8'h2E || c == 8'h2F || c == 8'h3A
          || c == 8'h3D || c == 8'h3F;
    is_printable = r;
  endfunction

  // Two ASCII digits as a value; only meaningful when both are digits.
  function automatic logic [6:0] pair_val(input logic [7:0] hi, input logic [7:0] lo);
    logic [3:0] h;
    logic [3:0] l;
    h = hi[3:0];
    l = lo[3:0];
    pair_val = 7'({h, 3'b000}) + 7'({h, 1'b0}) + 7'(l);
  endfunction

  // Field selector: 0 month, 1 day, 2 hour, otherwise minute or second.
  function automatic logic pair_bad(input logic [2:0] which, input logic [7:0] hi,
                                    input logic [7:0] lo);
    logic [6:0] v;
    logic r;
    v = pair_val(hi, lo);
    if (!is_dig(hi) || !is_dig(lo)) begin
      r = 1'b1;
    end else begin
      unique case (which)
        3'd0: r = (v < 7'd1) || (v > 7'd12);
        3'd1: r = (v < 7'd1) || (v > 7'd31);
        3'd2: r = v > 7'd23;
        default: r = v > 7'd59;
      endcase
    end
    pair_bad = r;
  endfunction

  function automatic logic tag_supported(input logic [4:0] t);
    tag_supported = t == TAG_BOOLEAN || t == TAG_INTEGER || t == TAG_BIT_STRING
      || t == TAG_OCTET || t == TAG_NULL || t == TAG_OID || t == TAG_REAL
      || t == TAG_ENUM || t == TAG_UTF8 || t == TAG_REL_OID || t == TAG_NUMERIC
      || t == TAG_PRINTABLE || t == TAG_IA5 || t == TAG_UTC_TIME
      || t == TAG_GEN_TIME || t == TAG_VISIBLE || t == TAG_UNIVERSAL || t == TAG_BMP;
  endfunction

  function automatic logic empty_bad(input logic [4:0] t);
    empty_bad = t == TAG_BOOLEAN || t == TAG_INTEGER || t == TAG_BIT_STRING
      || t == TAG_OID || t == TAG_ENUM || t == TAG_REL_OID || t == TAG_UTC_TIME
      || t == TAG_GEN_TIME;
  endfunction

endpackage

/* design/dpcv_byte_check.sv */
// Per-byte canonical-form checker for the DER primitive content validator.
// Pure combinational logic; depends on dpcv_pkg.
module dpcv_byte_check import dpcv_pkg::*; #(
  parameter int INDEX_BITS = 16
) (
  input  logic [4:0]            tag_number,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  logic [INDEX_BITS-1:0] byte_index,
  input  elem_state_t           st,
  output logic                  bad,
  output elem_state_t           st_nxt
);

  // Positions only matter below 32; larger saturated indexes read as "large".
  logic       idx_big;
  logic [4:0] idx;
  logic [7:0] b;
  logic [7:0] f;
  logic [2:0] mlen;
  logic [31:0] cp;
  logic [20:0] u8p;
  logic [2:0]  u8s;
  logic [2:0]  mant;
  logic [7:0]  mask;

  assign b = data_byte;
  assign idx_big = (byte_index >> 5) != '0;
  assign idx = byte_index[4:0];

  always_comb begin
    st_nxt = st;
    bad    = 1'b0;
    f      = (byte_index == '0) ? b : st.lead_byte;
    mlen   = 3'd2 + {1'b0, f[1:0]};
    cp     = '0;
    u8p    = '0;
    u8s    = '0;
    mant   = '0;
    mask   = '0;
    unique case (tag_number)
      TAG_BOOLEAN: bad = (byte_index != '0) || (b != 8'h00 && b != 8'hFF);
      TAG_INTEGER, TAG_ENUM: begin
        if (!idx_big && idx == 5'd1)
          bad = (st.lead_byte == 8'h00 && !b[7]) || (st.lead_byte == 8'hFF && b[7]);
      end
      TAG_BIT_STRING: begin
        mant = st.lead_byte[2:0];
        mask = 8'((9'd1 << mant) - 9'd1);
        if (byte_index == '0) bad = (b > 8'd7) || (last_byte && b != 8'h00);
        else if (last_byte) bad = (b & mask) != 8'h00;
      end
      TAG_NULL: bad = 1'b1;
      TAG_OID, TAG_REL_OID: begin
        bad = !st.in_cont && b == 8'h80;
        st_nxt.in_cont = b[7];
        if (last_byte && b[7]) bad = 1'b1;
      end
      TAG_REAL: begin
        if (!f[7]) begin
          if (byte_index != '0) bad = 1'b1;
          else bad = !f[6] || f > 8'h43 || !last_byte;
        end else if (f[5:4] != 2'b00 || f[3:2] != 2'b00 || f[1:0] == 2'b11) begin
          bad = 1'b1;
        end else begin
          if (!idx_big && idx == 5'd2 && mlen > 3'd2)
            bad = (st.prior_byte == 8'h00 && !b[7]) || (st.prior_byte == 8'hFF && b[7]);
          if (!idx_big && idx == 5'({2'b00, mlen} + 5'd1) && st.prior_byte == 8'h00)
            bad = 1'b1;
          if (last_byte && ((!idx_big && idx < 5'(mlen)) || !b[0])) bad = 1'b1;
        end
      end
      TAG_UTF8: begin
        if (st.u8_need == 3'd0) begin
          if (!b[7]) begin
            bad = 1'b0;
          end else if (b[7:5] == 3'b110) begin
            st_nxt.u8_point = 21'(b[4:0]);
            st_nxt.u8_need = 3'd2;
            st_nxt.u8_seen = 3'd1;
          end else if (b[7:4] == 4'b1110) begin
            st_nxt.u8_point = 21'(b[3:0]);
            st_nxt.u8_need = 3'd3;
            st_nxt.u8_seen = 3'd1;
          end else if (b[7:3] == 5'b11110) begin
            st_nxt.u8_point = 21'(b[2:0]);
            st_nxt.u8_need = 3'd4;
            st_nxt.u8_seen = 3'd1;
          end else begin
            bad = 1'b1;
          end
        end else if (b[7:6] != 2'b10) begin
          bad = 1'b1;
        end else begin
          u8p = {st.u8_point[14:0], b[5:0]};
          u8s = st.u8_seen + 3'd1;
          st_nxt.u8_point = u8p;
          st_nxt.u8_seen = u8s;
          if (u8s >= st.u8_need) begin
            st_nxt.u8_need = 3'd0;
            st_nxt.u8_seen = 3'd0;
            st_nxt.u8_point = '0;
            cp = 32'(u8p);
            bad = (st.u8_need == 3'd2 && cp < 32'h80)
               || (st.u8_need == 3'd3 && cp < 32'h800)
               || (st.u8_need == 3'd4 && cp < 32'h10000)
               || cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF);
          end
        end
        if (last_byte && st_nxt.u8_need != 3'd0) bad = 1'b1;
      end
      TAG_NUMERIC:   bad = !(is_dig(b) || b == 8'h20);
      TAG_PRINTABLE: bad = !is_printable(b);
      TAG_IA5:       bad = b > 8'h7F;
      TAG_VISIBLE:   bad = b < 8'h20 || b > 8'h7E;
      TAG_UTC_TIME: begin
        if (!idx_big && idx < 5'd12) begin
          bad = !is_dig(b);
          if (!bad && idx >= 5'd3 && idx[0])
            bad = pair_bad(3'((idx - 5'd3) >> 1), st.prior_byte, b);
        end else if (!idx_big && idx == 5'd12) begin
          bad = b != 8'h5A;
        end else begin
          bad = 1'b1;
        end
        if (last_byte && (idx_big || idx != 5'd12)) bad = 1'b1;
      end
      TAG_GEN_TIME: begin
        if (!idx_big && idx < 5'd14) begin
          bad = !is_dig(b);
          if (!bad && idx >= 5'd5 && idx[0])
            bad = pair_bad(3'((idx - 5'd5) >> 1), st.prior_byte, b);
        end else if (st.time_phase == TPH_MAIN) begin
          if (b == 8'h2E) st_nxt.time_phase = TPH_FRAC;
          else if (b == 8'h5A) st_nxt.time_phase = TPH_DONE;
          else bad = 1'b1;
        end else if (st.time_phase == TPH_FRAC) begin
          if (b == 8'h5A) begin
            bad = st.prior_byte == 8'h2E || st.prior_byte == 8'h30;
            st_nxt.time_phase = TPH_DONE;
          end else begin
            bad = !is_dig(b);
          end
        end else begin
          bad = 1'b1;
        end
        if (last_byte && ((!idx_big && idx < 5'd14) || st_nxt.time_phase != TPH_DONE))
          bad = 1'b1;
      end
      TAG_UNIVERSAL: begin
        bad = (st.unit_phase == 2'd0) && (b != 8'h00);
        if (st.unit_phase == 2'd3) begin
          cp = {st.unit_acc, b};
          bad = bad || cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF);
          st_nxt.unit_acc = '0;
        end else begin
          st_nxt.unit_acc = {st.unit_acc[15:0], b};
        end
        st_nxt.unit_phase = st.unit_phase + 2'd1;
        if (last_byte && st_nxt.unit_phase != 2'd0) bad = 1'b1;
      end
      TAG_BMP: begin
        if (st.unit_phase[0]) begin
          cp = 32'({st.prior_byte, b});
          bad = cp >= 32'hD800 && cp <= 32'hDFFF;
        end
        st_nxt.unit_phase = {1'b0, ~st.unit_phase[0]};
        if (last_byte && st_nxt.unit_phase != 2'd0) bad = 1'b1;
      end
      default: bad = 1'b0;
    endcase
    if (bad) st_nxt.error_seen = 1'b1;
    if (byte_index == '0) st_nxt.lead_byte = b;
    st_nxt.prior_byte = b;
  end

endmodule

/* design/der_primitive_content_validator.sv */
// Top level of the DER primitive content validator.
// Input register, per-byte checker (dpcv_byte_check) and result register; uses dpcv_pkg.
//
//   Port group | Direction | Carries
//   in_*       | input     | tag_number, data_byte, last_byte, empty_element
//   out_*      | output    | status (one result per element)
//
// A byte is checked combinationally in the input register, and its out_ verdict is
// registered as its last byte leaves; one byte is taken per cycle while in_stall is low.
// The rate is set by the single element-state register that each byte updates.
// rst_n is synchronous and clears all element state and both valid flags.
// A stall on out_ holds the result; in_stall rises only when the input register holds
// an element's last request while a stalled result still waits in the output register.
module der_primitive_content_validator import dpcv_pkg::*; #(
  parameter int INDEX_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [4:0] in_tag_number,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       in_empty_element,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status
);

  logic                  q_valid_r;
  logic [4:0]            q_tag_r;
  logic [7:0]            q_byte_r;
  logic                  q_last_r;
  logic                  q_empty_r;
  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [INDEX_BITS-1:0] idx_r;
  logic [INDEX_BITS-1:0] idx_nxt;
  elem_state_t           st_r;
  elem_state_t           st_nxt;
  elem_state_t           chk_st;
  logic                  chk_bad;
  logic                  q_fire;
  logic                  q_ends;
  logic                  q_block;
  logic                  in_fire;
  logic [1:0]            status_nxt;

  dpcv_byte_check #(.INDEX_BITS(INDEX_BITS)) u_check (
    .tag_number(q_tag_r),
    .data_byte (q_byte_r),
    .last_byte (q_last_r),
    .byte_index(idx_r),
    .st        (st_r),
    .bad       (chk_bad),
    .st_nxt    (chk_st)
  );

  // A request that ends an element needs the result register free.
  assign q_ends  = q_last_r || q_empty_r;
  assign q_block = q_valid_r && q_ends && out_valid_r && out_stall;
  assign q_fire  = q_valid_r && !q_block;
  assign in_stall = q_block;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    st_nxt  = chk_st;
    idx_nxt = (idx_r == '1) ? idx_r : idx_r + 1'b1;
    if (!tag_supported(q_tag_r)) status_nxt = STATUS_UNSUPPORTED;
    else if (q_empty_r) status_nxt = empty_bad(q_tag_r) ? STATUS_INVALID : STATUS_OK;
    else status_nxt = (chk_st.error_seen) ? STATUS_INVALID : STATUS_OK;
    if (q_ends) begin
      st_nxt  = '0;
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      idx_r       <= '0;
    end else begin
      if (in_fire) q_valid_r <= 1'b1;
      else if (q_fire) q_valid_r <= 1'b0;
      if (q_fire) begin
        st_r  <= st_nxt;
        idx_r <= idx_nxt;
      end
      if (q_fire && q_ends) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_tag_r   <= in_tag_number;
      q_byte_r  <= in_data_byte;
      q_last_r  <= in_last_byte;
      q_empty_r <= in_empty_element;
    end
    if (q_fire && q_ends) out_status_r <= status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  a_no_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("status code out of range");
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (q_valid_r && out_valid_r)) else $error("stall without full stages");
  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (q_fire && q_ends) |=> (idx_r == '0 && st_r == '0)) else $error("element state kept");
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (q_fire && q_ends) |=> out_valid) else $error("result lost");
`endif

endmodule
